// ===== rtl/mat3_pkg.sv =====
// Shared types and constants for the 3x3 matrix arithmetic unit.
// Holds the action and operation codes, the control word layout and the microprogram ROM.
// No dependencies.
`timescale 1ns / 1ps

package mat3_pkg;

  typedef enum logic [1:0] {
    ACT_WR_A = 2'd0,
    ACT_WR_B = 2'd1,
    ACT_RD_A = 2'd2,
    ACT_RUN  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_TRN = 3'd3,
    OP_SCL = 3'd4
  } op_t;

  // read address source
  typedef enum logic {
    ADDR_ELEM = 1'b0,
    ADDR_LOOP = 1'b1
  } addr_mode_t;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_READ   = 2'd1,
    EMIT_RESULT = 2'd2
  } emit_t;

  typedef enum logic [1:0] {
    JC_NEXT      = 2'd0,
    JC_GOTO      = 2'd1,
    JC_K_MORE    = 2'd2,
    JC_ELEM_MORE = 2'd3
  } jump_t;

  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] PC_IDLE     = 3'd0;
  localparam logic [PC_W-1:0] PC_RD_ISSUE = 3'd1;
  localparam logic [PC_W-1:0] PC_RD_EMIT  = 3'd2;
  localparam logic [PC_W-1:0] PC_LP_READ  = 3'd3;
  localparam logic [PC_W-1:0] PC_LP_MUL   = 3'd4;
  localparam logic [PC_W-1:0] PC_LP_ACC   = 3'd5;
  localparam logic [PC_W-1:0] PC_LP_EMIT  = 3'd6;

  typedef struct packed {
    logic            rd_en;
    addr_mode_t      addr_mode;
    logic            ld_prod;
    logic            ld_acc;
    logic            adv_k;
    emit_t           emit;
    logic            adv_elem;
    jump_t           jc;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic k_last;
    logic elem_last;
  } dp_stat_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    w.jc = JC_GOTO;
    w.target = PC_IDLE;
    case (pc)
      PC_RD_ISSUE: begin
        w.rd_en = 1'b1;
        w.addr_mode = ADDR_ELEM;
        w.jc = JC_NEXT;
      end
      PC_RD_EMIT: begin
        w.emit = EMIT_READ;
      end
      PC_LP_READ: begin
        w.rd_en = 1'b1;
        w.addr_mode = ADDR_LOOP;
        w.jc = JC_NEXT;
      end
      PC_LP_MUL: begin
        w.ld_prod = 1'b1;
        w.jc = JC_NEXT;
      end
      PC_LP_ACC: begin
        w.ld_acc = 1'b1;
        w.adv_k = 1'b1;
        w.jc = JC_K_MORE;
        w.target = PC_LP_READ;
      end
      PC_LP_EMIT: begin
        w.emit = EMIT_RESULT;
        w.adv_elem = 1'b1;
        w.jc = JC_ELEM_MORE;
        w.target = PC_LP_READ;
      end
      default: begin
        w.jc = JC_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mat3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mat3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mat3_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on mat3_pkg.
`timescale 1ns / 1ps

module mat3_useq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         action,
  input  logic [2:0]         op,
  input  mat3_pkg::dp_stat_t stat,
  output mat3_pkg::ucw_t     cw,
  output logic               busy
);

  logic [mat3_pkg::PC_W-1:0] upc;
  logic [mat3_pkg::PC_W-1:0] upc_next;

  assign cw   = mat3_pkg::ucode(upc);
  assign busy = (upc != mat3_pkg::PC_IDLE);

  always_comb begin
    upc_next = upc;
    if (accept) begin
      if (action == mat3_pkg::ACT_RD_A) begin
        upc_next = mat3_pkg::PC_RD_ISSUE;
      end else if (action == mat3_pkg::ACT_RUN && op <= mat3_pkg::OP_SCL) begin
        upc_next = mat3_pkg::PC_LP_READ;
      end
    end else begin
      case (cw.jc)
        mat3_pkg::JC_NEXT:      upc_next = upc + 1'b1;
        mat3_pkg::JC_GOTO:      upc_next = cw.target;
        mat3_pkg::JC_K_MORE:    upc_next = stat.k_last ? upc + 1'b1 : cw.target;
        mat3_pkg::JC_ELEM_MORE: upc_next = stat.elem_last ? mat3_pkg::PC_IDLE : cw.target;
        default:                upc_next = mat3_pkg::PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= mat3_pkg::PC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/mat3_dp.sv =====
// Datapath: matrix storage with valid bits, loop counters, multiplier, accumulator, output regs.
// Depends on mat3_pkg and mat3_ram.
`timescale 1ns / 1ps

module mat3_dp #(
  parameter int DIM = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         action,
  input  logic [2:0]         op,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  mat3_pkg::ucw_t     cw,
  output mat3_pkg::dp_stat_t stat,
  output logic               strobe,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               last
);

  localparam int N     = DIM * DIM;
  localparam int AW    = $clog2(N);
  localparam int IW    = $clog2(DIM);
  localparam int ACC_W = 48 + $clog2(DIM);

  localparam logic signed [ACC_W-1:0] Q_MAX = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] Q_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};
  localparam logic [IW-1:0] I_LAST = IW'(DIM - 1);
  localparam logic [AW-1:0] D_A    = AW'(DIM);

  // latched item
  logic [2:0]         op_r;
  logic [1:0]         row_r;
  logic [1:0]         col_r;
  logic signed [31:0] val_r;
  logic               inside_r;

  logic [IW-1:0] i, j, k;
  logic [N-1:0]  vld_a, vld_b;
  logic          rv_a, rv_b;

  logic signed [63:0]      prod;
  logic signed [32:0]      sumr;
  logic signed [ACC_W-1:0] acc;

  logic               inside_in;
  logic [AW-1:0]      waddr_in;
  logic [AW-1:0]      eaddr;
  logic [AW-1:0]      ai, aj, ak;
  logic [AW-1:0]      loop_a, loop_b;
  logic [AW-1:0]      raddr_a, raddr_b;
  logic [31:0]        rdata_a, rdata_b;
  logic signed [31:0] a_eff, b_eff, mul_x;
  logic signed [32:0] a33, b33;
  logic signed [47:0] psh;
  logic signed [ACC_W-1:0] term;
  logic signed [31:0] sat_val;
  logic               we_a, we_b;

  assign inside_in = (row < DIM) && (col < DIM);
  assign waddr_in  = inside_in ? AW'(row) * D_A + AW'(col) : '0;
  assign eaddr     = inside_r ? AW'(row_r) * D_A + AW'(col_r) : '0;

  assign ai = AW'(i);
  assign aj = AW'(j);
  assign ak = AW'(k);

  always_comb begin
    if (op_r == mat3_pkg::OP_MUL) begin
      loop_a = ai * D_A + ak;
      loop_b = ak * D_A + aj;
    end else if (op_r == mat3_pkg::OP_TRN) begin
      loop_a = aj * D_A + ai;
      loop_b = ai * D_A + aj;
    end else begin
      loop_a = ai * D_A + aj;
      loop_b = ai * D_A + aj;
    end
  end

  assign raddr_a = (cw.addr_mode == mat3_pkg::ADDR_ELEM) ? eaddr : loop_a;
  assign raddr_b = (cw.addr_mode == mat3_pkg::ADDR_ELEM) ? eaddr : loop_b;

  assign we_a = accept && action == mat3_pkg::ACT_WR_A && inside_in;
  assign we_b = accept && action == mat3_pkg::ACT_WR_B && inside_in;

  mat3_ram #(.WIDTH(32), .DEPTH(N)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_in),
    .wdata (value),
    .re    (cw.rd_en),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mat3_ram #(.WIDTH(32), .DEPTH(N)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_in),
    .wdata (value),
    .re    (cw.rd_en),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // never-written entries read as zero
  assign a_eff = rv_a ? $signed(rdata_a) : 32'sd0;
  assign b_eff = rv_b ? $signed(rdata_b) : 32'sd0;
  assign mul_x = (op_r == mat3_pkg::OP_SCL) ? val_r : b_eff;
  assign a33   = {a_eff[31], a_eff};
  assign b33   = {b_eff[31], b_eff};

  // floor shift by 16
  assign psh  = prod[63:16];
  assign term = (op_r == mat3_pkg::OP_MUL || op_r == mat3_pkg::OP_SCL) ?
                ACC_W'(psh) : ACC_W'(sumr);

  assign sat_val = (acc > Q_MAX) ? 32'sh7FFF_FFFF :
                   (acc < Q_MIN) ? -32'sh7FFF_FFFF - 32'sd1 : acc[31:0];

  assign stat.k_last    = (op_r != mat3_pkg::OP_MUL) || (k == I_LAST);
  assign stat.elem_last = (i == I_LAST) && (j == I_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a  <= '0;
      vld_b  <= '0;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      strobe <= 1'b0;
    end else begin
      if (we_a) begin
        vld_a[waddr_in] <= 1'b1;
      end
      if (we_b) begin
        vld_b[waddr_in] <= 1'b1;
      end
      if (accept) begin
        i <= '0;
        j <= '0;
        k <= '0;
      end else begin
        if (cw.adv_k) begin
          k <= stat.k_last ? '0 : k + 1'b1;
        end
        if (cw.adv_elem) begin
          if (j == I_LAST) begin
            j <= '0;
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
      end
      strobe <= (cw.emit != mat3_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      row_r    <= row;
      col_r    <= col;
      val_r    <= value;
      inside_r <= inside_in;
    end
    if (cw.rd_en) begin
      rv_a <= vld_a[raddr_a];
      rv_b <= vld_b[raddr_b];
    end
    if (cw.ld_prod) begin
      prod <= a_eff * mul_x;
      if (op_r == mat3_pkg::OP_SUB) begin
        sumr <= a33 - b33;
      end else if (op_r == mat3_pkg::OP_TRN) begin
        sumr <= a33;
      end else begin
        sumr <= a33 + b33;
      end
    end
    if (cw.ld_acc) begin
      acc <= (op_r == mat3_pkg::OP_MUL && k != '0) ? acc + term : term;
    end
    case (cw.emit)
      mat3_pkg::EMIT_READ: begin
        out_row   <= row_r;
        out_col   <= col_r;
        out_value <= (inside_r && rv_a) ? $signed(rdata_a) : 32'sd0;
        last      <= 1'b1;
      end
      mat3_pkg::EMIT_RESULT: begin
        out_row   <= 2'(i);
        out_col   <= 2'(j);
        out_value <= sat_val;
        last      <= stat.elem_last;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/matrix3_add_sub_mul_transpose.sv =====
// A write completes in its accept cycle; a read issues in RD_ISSUE and emits in RD_EMIT.
// Add, subtract, transpose and scale take each element through read, compute, load and emit;
// multiply repeats read, multiply and accumulate per k before it emits, in the microprogram loop
// through each matrix RAM's single read port. Busy blocks new items. Results cannot be stalled.
// Reset is synchronous: clears the sequencer and the per-entry valid bits, so both matrices
// read as zero at once; no clearing pass over the RAMs.
`timescale 1ns / 1ps

module matrix3_add_sub_mul_transpose #(
  parameter int DIM = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [2:0]         op,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               last
);

  logic               accept;
  mat3_pkg::ucw_t     cw;
  mat3_pkg::dp_stat_t stat;

  assign accept = start && !busy;

  mat3_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (action),
    .op     (op),
    .stat   (stat),
    .cw     (cw),
    .busy   (busy)
  );

  mat3_dp #(.DIM(DIM)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .op        (op),
    .row       (row),
    .col       (col),
    .value     (value),
    .cw        (cw),
    .stat      (stat),
    .strobe    (strobe),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .last      (last)
  );

  // a valid run starts the sequencer
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    accept && action == mat3_pkg::ACT_RUN && op <= mat3_pkg::OP_SCL |=> busy)
    else $error("run transfer did not start the sequencer");

  // writes finish in the accept cycle
  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (action == mat3_pkg::ACT_WR_A || action == mat3_pkg::ACT_WR_B) |=> !busy)
    else $error("write transfer left the block busy");

  a_rd_result: assert property (@(posedge clk) disable iff (rst)
    accept && action == mat3_pkg::ACT_RD_A |-> ##3 (strobe && last))
    else $error("read result missing");

  // every program ends on its final result
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("sequencer went idle without a final result");

endmodule
